>>> hdl/swfrm_pkg.sv
// ----------------------------------------------------------------------------
// swfrm_pkg
// Shared types and constants of the sliding window frame rate meter.
// ----------------------------------------------------------------------------
package swfrm_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RATE_W    = 26;
  localparam int unsigned FIW_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MS_W      = 10;

  localparam logic [MS_W-1:0]   MS_PER_S = 10'd1000;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  localparam logic [TIME_W-1:0] WINDOW_RST    = 32'd1000;
  localparam logic [TIME_W-1:0] INTERVAL_RST  = 32'd500;
  localparam logic [RATE_W-1:0] TOLERANCE_RST = 26'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INT_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_TOL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_START,
    ST_DIVIDE,
    ST_DECIDE,
    ST_EMIT
  } swfrm_state_e;

  typedef struct packed {
    logic accept;
    logic age_load;
    logic evict;
    logic div_start;
    logic rate_load;
    logic report;
  } swfrm_cmd_t;

  typedef struct packed {
    logic evict_ok;
    logic age_gt_interval;
    logic div_done;
    logic report_ok;
    logic out_busy;
  } swfrm_status_t;

endpackage

>>> hdl/swfrm_ram.sv
// ----------------------------------------------------------------------------
// swfrm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swfrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/swfrm_div.sv
// ----------------------------------------------------------------------------
// swfrm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swfrm_div #(
  parameter int unsigned NUM_W = 43,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,   // held stable while running
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_i};
  assign fits  = trial >= {1'b0, den_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(NUM_W);
      rem_d = '0;
      quo_d = num_i;
    end else if (run_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hdl/swfrm_ctrl.sv
// ----------------------------------------------------------------------------
// swfrm_ctrl
// Sequencer: accept, evict stale stamps, divide, decide and emit a report.
// ----------------------------------------------------------------------------
module swfrm_ctrl
  import swfrm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  swfrm_status_t status_i,
  output swfrm_cmd_t    cmd_o
);

  swfrm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.evict_ok) begin
          state_d = ST_READ;
        end else if (status_i.age_gt_interval) begin
          state_d = ST_START;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (status_i.div_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = status_i.report_ok ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (!status_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.age_load = 1'b1;
        cmd_o.evict    = status_i.evict_ok;
      end
      ST_START:  cmd_o.div_start = 1'b1;
      ST_DIVIDE: cmd_o.rate_load = status_i.div_done;
      ST_EMIT:   cmd_o.report    = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/swfrm_dp.sv
// ----------------------------------------------------------------------------
// swfrm_dp
// Datapath: config registers, stamp ring, age math, rate divider, output reg.
// ----------------------------------------------------------------------------
module swfrm_dp
  import swfrm_pkg::*;
#(
  parameter int unsigned RING_DEPTH     = 256,
  parameter int unsigned RATE_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swfrm_cmd_t            cmd_i,
  output swfrm_status_t         status_o,
  input  logic [TIME_W-1:0]     frame_time_ms_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RATE_W-1:0]     frame_rate_o,
  output logic [FIW_W-1:0]      frames_in_window_o
);

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned PROD_W = CNT_W + MS_W;
  localparam int unsigned NUM_W  = PROD_W + RATE_FRAC_BITS;
  localparam int unsigned QX_W   = NUM_W + RATE_W;

  logic [TIME_W-1:0] window_q, interval_q;
  logic [RATE_W-1:0] tol_q;
  logic [PTR_W-1:0]  wp_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] stamp_q, age_q, last_time_q;
  logic [RATE_W-1:0] rate_q, last_rate_q, out_rate_q;
  logic [FIW_W-1:0]  out_fiw_q;
  logic              out_valid_q;

  logic [PTR_W-1:0]  wp_inc;
  logic [CNT_W:0]    old_sum;
  logic [PTR_W-1:0]  oldest;
  logic [TIME_W-1:0] rd_stamp, age_w, since;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num, quot;
  logic [QX_W-1:0]   quot_x;
  logic [RATE_W-1:0] rate_sat, rate_diff;
  logic              div_done;
  logic [CNT_W+FIW_W-1:0] cnt_x;

  // ring addressing
  assign wp_inc  = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign old_sum = (CNT_W+1)'(wp_q) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(cnt_q);
  assign oldest  = (old_sum >= (CNT_W+1)'(RING_DEPTH))
                   ? PTR_W'(old_sum - (CNT_W+1)'(RING_DEPTH)) : PTR_W'(old_sum);

  swfrm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_q),
    .wdata_i (frame_time_ms_i),
    .raddr_i (oldest),
    .rdata_o (rd_stamp)
  );

  assign age_w = stamp_q - rd_stamp;

  // rate = count * 1000 * 2^frac / age
  assign prod = PROD_W'(cnt_q) * PROD_W'(MS_PER_S);
  assign num  = NUM_W'(prod) << RATE_FRAC_BITS;

  swfrm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (age_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign quot_x   = QX_W'(quot);
  assign rate_sat = (quot_x > QX_W'(RATE_MAX)) ? RATE_MAX : quot_x[RATE_W-1:0];

  assign rate_diff = (rate_q >= last_rate_q) ? rate_q - last_rate_q : last_rate_q - rate_q;
  assign since     = stamp_q - last_time_q;
  assign cnt_x     = (CNT_W+FIW_W)'(cnt_q);

  always_comb begin
    status_o                 = '0;
    status_o.evict_ok        = (age_w >= window_q) && (cnt_q > CNT_W'(1));
    status_o.age_gt_interval = age_w > interval_q;
    status_o.div_done        = div_done;
    status_o.report_ok       = (rate_diff >= tol_q) && (since >= interval_q);
    status_o.out_busy        = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RST;
      interval_q  <= INTERVAL_RST;
      tol_q       <= TOLERANCE_RST;
      wp_q        <= '0;
      cnt_q       <= '0;
      last_time_q <= '0;
      last_rate_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_MS:     window_q   <= cfg_data_i;
          CFG_REPORT_INT_MS: interval_q <= cfg_data_i;
          CFG_RATE_TOL:      tol_q      <= cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        wp_q <= wp_inc;
        if (cnt_q != CNT_W'(RING_DEPTH)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (cmd_i.evict) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.report) begin
        last_time_q <= stamp_q;
        last_rate_q <= rate_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stamp_q <= frame_time_ms_i;
    end
    if (cmd_i.age_load) begin
      age_q <= age_w;
    end
    if (cmd_i.rate_load) begin
      rate_q <= rate_sat;
    end
    if (cmd_i.report) begin
      out_rate_q <= rate_q;
      out_fiw_q  <= cnt_x[FIW_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_rate_o       = out_rate_q;
  assign frames_in_window_o = out_fiw_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RING_DEPTH))
    else $error("entry count above ring depth");

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < PTR_W'(RING_DEPTH - 1) || wp_q == PTR_W'(RING_DEPTH - 1))
    else $error("write pointer outside ring");

  a_evict_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> cnt_q > CNT_W'(1))
    else $error("eviction of the newest entry");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |-> !out_valid_q)
    else $error("report overwrites a pending result");

  a_report_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |=> out_valid_q && last_rate_q == out_rate_q)
    else $error("report did not load output and last rate together");
`endif

endmodule

>>> hdl/sliding_window_frame_rate_meter.sv
// Flow: for each ring entry checked, one read then one compare; then start,
// divide, decide and emit, where emit waits while a report is still pending.
// One frame at a time: a new frame is taken only in idle, once the previous
// frame's checks and any divide and report are done; the pace is set by
// the one-bit-per-cycle divider and the single ring read port.
// Reset: asynchronous, clears config to defaults, pointers, counts, report state.
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_meter
// Frame rate over a sliding window of timestamps, reported on change.
// ----------------------------------------------------------------------------
module sliding_window_frame_rate_meter
  import swfrm_pkg::*;
#(
  parameter int unsigned RING_DEPTH     = 256,
  parameter int unsigned RATE_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     frame_time_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RATE_W-1:0]     frame_rate_o,
  output logic [FIW_W-1:0]      frames_in_window_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  swfrm_cmd_t    cmd;
  swfrm_status_t status;

  assign cfg_ready_o = 1'b1;

  swfrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swfrm_dp #(
    .RING_DEPTH     (RING_DEPTH),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .frame_time_ms_i    (frame_time_ms_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frame_rate_o       (frame_rate_o),
    .frames_in_window_o (frames_in_window_o)
  );

endmodule

>>> bench/tb_sliding_window_frame_rate_meter.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_frame_rate_meter
// Self-checking bench: frame stamps go in through a randomly idling driver,
// a local model of the timestamp ring predicts each rate report, and a
// randomly stalling monitor compares every report field against it.
// ----------------------------------------------------------------------------
module tb_sliding_window_frame_rate_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import swfrm_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned FRAC  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [FIW_W-1:0]  frames;
  } rate_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [TIME_W-1:0]     frame_time_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [RATE_W-1:0]     frame_rate_o;
  logic [FIW_W-1:0]      frames_in_window_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // stamps waiting to be offered, reports waiting to come out
  logic [TIME_W-1:0] pending_stamps[$];
  rate_report_t      expected_reports[$];
  rate_report_t      next_report;

  // register shadows
  logic [TIME_W-1:0] win_ms      = WINDOW_RST;
  logic [TIME_W-1:0] interval_ms = INTERVAL_RST;
  logic [RATE_W-1:0] tol_rate    = TOLERANCE_RST;

  // local copy of the ring and report state
  logic [TIME_W-1:0] stamp_hist [SLOTS];
  logic [7:0]        hist_wr = '0;
  logic [FIW_W-1:0]  hist_count = '0;
  logic [TIME_W-1:0] last_time = '0;
  logic [RATE_W-1:0] last_rate = '0;

  int  mismatches = 0;
  int  reports_checked = 0;
  int  frames_accepted = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  logic quiet = 1'b0;
  logic rx_hold = 1'b0;

  sliding_window_frame_rate_meter #(
    .RING_DEPTH    (SLOTS),
    .RATE_FRAC_BITS(FRAC)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .frame_time_ms_i   (frame_time_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_rate_o      (frame_rate_o),
    .frames_in_window_o(frames_in_window_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Push one stamp into the ring, age out old ones, and decide on a report.
  function automatic logic predict_report(input logic [TIME_W-1:0] stamp,
                                          output rate_report_t rpt);
    logic [7:0]        oldest;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] since;
    logic [63:0]       quot;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] delta;
    rpt = '0;
    stamp_hist[hist_wr] = stamp;
    hist_wr = hist_wr + 8'd1;
    if (hist_count < SLOTS) hist_count = hist_count + 1'b1;
    oldest = hist_wr - hist_count[7:0];
    age = stamp - stamp_hist[oldest];
    // newest entry always stays
    while (age >= win_ms && hist_count > 1) begin
      hist_count = hist_count - 1'b1;
      oldest = hist_wr - hist_count[7:0];
      age = stamp - stamp_hist[oldest];
    end
    if (age <= interval_ms) return 1'b0;
    quot = ((64'(hist_count) * 64'(MS_PER_S)) << FRAC) / 64'(age);
    rate = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
    delta = (rate >= last_rate) ? rate - last_rate : last_rate - rate;
    if (delta < tol_rate) return 1'b0;
    since = stamp - last_time;
    if (since < interval_ms) return 1'b0;
    last_time = stamp;
    last_rate = rate;
    rpt.rate = rate;
    rpt.frames = hist_count;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // stamp driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        frames_accepted <= frames_accepted + 1;
        if (predict_report(frame_time_ms_i, next_report))
          expected_reports.push_back(next_report);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offer until the transfer
      end else if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_stamps.size() != 0) begin
        in_valid_i <= 1'b1;
        frame_time_ms_i <= pending_stamps.pop_front();
        tx_gap <= idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch($sformatf("unexpected report: rate %0h frames %0d",
                                  frame_rate_o, frames_in_window_o));
        end else begin
          next_report = expected_reports.pop_front();
          reports_checked++;
          if (frame_rate_o !== next_report.rate ||
              frames_in_window_o !== next_report.frames)
            flag_mismatch($sformatf("report %0d: exp rate %0h frames %0d, got rate %0h frames %0d",
                                    reports_checked, next_report.rate, next_report.frames,
                                    frame_rate_o, frames_in_window_o));
        end
      end
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall != 0) begin
        out_ready_i <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 7) == 0) rx_stall <= idle_len();
      end
    end
  end

  // long receiver hold-off once reports are flowing, so the block backs up
  initial begin
    do @(posedge clk_i); while (!(frames_accepted >= 350 && out_valid_o));
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WINDOW_MS:     win_ms = data;
      CFG_REPORT_INT_MS: interval_ms = data;
      CFG_RATE_TOL:      tol_rate = data[RATE_W-1:0];
      default: ;
    endcase
  endtask

  // checked at the falling edge so driver updates have landed
  task automatic settle();
    do @(negedge clk_i);
    while (pending_stamps.size() != 0 || in_valid_i || expected_reports.size() != 0);
    // frames that report nothing may still be in flight
    repeat (600) @(posedge clk_i);
  endtask

  task automatic queue_frames(inout logic [TIME_W-1:0] t, input int n,
                              input int lo, input int hi);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) t = $urandom();  // broken sequence
      else t = t + 32'($urandom_range(lo, hi));
      pending_stamps.push_back(t);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    logic [31:0] w;
    logic [31:0] iv;
    logic [31:0] tl;
    int queued;
    int lo;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: stamp extremes, wrap of the clock, then a jump down to one entry
    pending_stamps.push_back(32'h0);
    pending_stamps.push_back(32'hFFFF_FFFF);
    for (int k = 1; k <= 10; k++) pending_stamps.push_back(32'hFFFF_FFFF + 32'(100 * k));
    pending_stamps.push_back(32'd5999);
    settle();

    // zero window: eviction stops at the newest entry
    write_reg(CFG_WINDOW_MS, 32'd0);
    write_reg(CFG_REPORT_INT_MS, 32'd0);
    write_reg(CFG_RATE_TOL, 32'd0);
    write_reg(CFG_UNUSED, $urandom());
    pending_stamps.push_back(32'd77);
    pending_stamps.push_back(32'd77);
    pending_stamps.push_back(32'd78);
    pending_stamps.push_back(32'd80);
    settle();

    // two millisecond window, repeated stamps, very high rates
    write_reg(CFG_WINDOW_MS, 32'd2);
    pending_stamps.push_back(32'd100);
    pending_stamps.push_back(32'd101);
    pending_stamps.push_back(32'd101);
    pending_stamps.push_back(32'd102);
    settle();

    // all-ones registers: nothing can report
    write_reg(CFG_WINDOW_MS, 32'hFFFF_FFFF);
    write_reg(CFG_REPORT_INT_MS, 32'hFFFF_FFFF);
    write_reg(CFG_RATE_TOL, 32'hFFFF_FFFF);
    pending_stamps.push_back(32'h8000_0000);
    pending_stamps.push_back(32'h8000_0001);
    pending_stamps.push_back(32'h7FFF_FFFF);
    settle();

    // ring overflow: window never expires, count pins at full depth
    write_reg(CFG_REPORT_INT_MS, 32'd300);
    write_reg(CFG_RATE_TOL, 32'd0);
    t = $urandom();
    queue_frames(t, 300, 1, 3);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom();
        iv = $urandom();
        tl = $urandom();
      end else begin
        w = $urandom_range(30, 600);
        iv = $urandom_range(1, w - 1);
        tl = $urandom_range(0, 3000);
      end
      write_reg(CFG_WINDOW_MS, w);
      write_reg(CFG_REPORT_INT_MS, iv);
      write_reg(CFG_RATE_TOL, tl);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom());
      quiet <= ($urandom_range(0, 3) == 0);
      t = $urandom();
      queued = 0;
      // segments of steady frame spacing so the rate moves in steps
      while (queued < 80) begin
        lo = $urandom_range(1, 30);
        queue_frames(t, 10, lo, lo + $urandom_range(0, 20));
        queued += 10;
      end
      settle();
    end

    if (expected_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
